@@ rtl/core/b64lw_pkg.sv @@
// Shared types, constants and the Base64 alphabet for the line-wrapped encoder.
`timescale 1ns / 1ps
`default_nettype none
package b64lw_pkg;

  localparam int unsigned CHAR_W  = 7;
  localparam int unsigned COUNT_W = 7;
  localparam int unsigned SLOT_N  = 4;
  localparam int unsigned SLOT_W  = 2;

  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_THIRD  = 2'd2;

  localparam logic [CHAR_W-1:0]  PAD_CHAR     = 7'd61;
  localparam logic [CHAR_W-1:0]  NEWLINE_CHAR = 7'd10;
  localparam logic [COUNT_W-1:0] GROUP_CHARS  = 7'd4;

  typedef logic [CHAR_W-1:0]  char_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [SLOT_W-1:0]  slot_t;

  typedef struct packed {
    char_t [SLOT_N-1:0] chars;
    slot_t              last_slot;
    logic               fin;
  } group_t;

  function automatic char_t b64_sym(input logic [5:0] v);
    char_t c;
    if (v < 6'd26) begin
      c = 7'd65 + {1'b0, v};
    end else if (v < 6'd52) begin
      c = 7'd71 + {1'b0, v};
    end else if (v < 6'd62) begin
      c = {1'b0, v} - 7'd4;
    end else if (v == 6'd62) begin
      c = 7'd43;
    end else begin
      c = 7'd47;
    end
    return c;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/b64lw_in_if.sv @@
// Input channel interface: one raw byte per word with a final flag.
`timescale 1ns / 1ps
`default_nettype none
interface b64lw_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface
`default_nettype wire

@@ rtl/core/b64lw_out_if.sv @@
// Result channel interface: one ASCII character per word with run and message marks.
`timescale 1ns / 1ps
`default_nettype none
interface b64lw_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_char;
  logic       end_of_run;
  logic       end_of_message;

  modport source (output valid, output out_char, output end_of_run,
                  output end_of_message, input ready);
  modport sink (input valid, input out_char, input end_of_run,
                input end_of_message, output ready);
endinterface
`default_nettype wire

@@ rtl/core/b64lw_group_enc.sv @@
// Group encoder: group phase, carry and line count state plus per-byte character build.
`timescale 1ns / 1ps
`default_nettype none
module b64lw_group_enc #(
  parameter int LINE_CHARS = 76
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           advance,
  input  wire logic [7:0]     data_byte,
  input  wire logic           final_byte,
  output b64lw_pkg::group_t   grp
);
  import b64lw_pkg::*;

  logic [1:0] phase_r, phase_nxt;
  logic [3:0] carry_r, carry_nxt;
  count_t     count_r, count_nxt;
  count_t     count_sum;

  assign count_sum = count_r + GROUP_CHARS;

  always_comb begin
    grp.chars     = '0;
    grp.last_slot = '0;
    grp.fin       = final_byte;
    phase_nxt     = phase_r;
    carry_nxt     = carry_r;
    count_nxt     = count_r;
    case (phase_r)
      PH_SECOND: begin
        grp.chars[0] = b64_sym({carry_r[1:0], data_byte[7:4]});
        if (final_byte) begin
          grp.chars[1]  = b64_sym({data_byte[3:0], 2'b00});
          grp.chars[2]  = PAD_CHAR;
          grp.last_slot = 2'd2;
        end else begin
          carry_nxt = data_byte[3:0];
          phase_nxt = PH_THIRD;
        end
      end
      PH_THIRD: begin
        grp.chars[0] = b64_sym({carry_r, data_byte[7:6]});
        grp.chars[1] = b64_sym(data_byte[5:0]);
        if (count_sum >= COUNT_W'(LINE_CHARS)) begin
          grp.chars[2]  = NEWLINE_CHAR;
          grp.last_slot = 2'd2;
          count_nxt     = '0;
        end else begin
          grp.last_slot = 2'd1;
          count_nxt     = count_sum;
        end
        carry_nxt = '0;
        phase_nxt = PH_FIRST;
      end
      default: begin
        grp.chars[0] = b64_sym(data_byte[7:2]);
        if (final_byte) begin
          grp.chars[1]  = b64_sym({data_byte[1:0], 4'b0000});
          grp.chars[2]  = PAD_CHAR;
          grp.chars[3]  = PAD_CHAR;
          grp.last_slot = 2'd3;
        end else begin
          carry_nxt = {2'b00, data_byte[1:0]};
          phase_nxt = PH_SECOND;
        end
      end
    endcase
    if (final_byte) begin
      phase_nxt = PH_FIRST;
      carry_nxt = '0;
      count_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FIRST;
      carry_r <= '0;
      count_r <= '0;
    end else if (advance) begin
      phase_r <= phase_nxt;
      carry_r <= carry_nxt;
      count_r <= count_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/b64lw_char_buf.sv @@
// Result buffer: holds up to four characters of one byte and sends them one per word.
`timescale 1ns / 1ps
`default_nettype none
module b64lw_char_buf (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load,
  input  wire b64lw_pkg::group_t grp,
  output logic                   can_load,
  b64lw_out_if.source            out_ch
);
  import b64lw_pkg::*;

  group_t grp_r;
  slot_t  slot_r, slot_nxt;
  logic   valid_r, valid_nxt;
  logic   at_last;
  logic   take;

  assign at_last  = (slot_r == grp_r.last_slot);
  assign take     = valid_r && out_ch.ready;
  assign can_load = !valid_r || (take && at_last);

  assign out_ch.valid          = valid_r;
  assign out_ch.out_char       = grp_r.chars[slot_r];
  assign out_ch.end_of_run     = at_last;
  assign out_ch.end_of_message = at_last && grp_r.fin;

  always_comb begin
    valid_nxt = valid_r;
    slot_nxt  = slot_r;
    if (load) begin
      valid_nxt = 1'b1;
      slot_nxt  = '0;
    end else if (take) begin
      if (at_last) begin
        valid_nxt = 1'b0;
      end else begin
        slot_nxt = slot_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      slot_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      slot_r  <= slot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      grp_r <= grp;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/base64_line_wrapped_encoder.sv @@
// Top level of the streaming Base64 encoder with newline after every LINE_CHARS characters.
//
//   channel  dir  word
//   in_ch    in   data_byte[7:0], final_byte
//   out_ch   out  out_char[6:0], end_of_run, end_of_message
//
// A byte is held in the input register, then its one to four characters are built in a
// single pass and loaded into the result buffer, which sends one per cycle while out_ch
// is ready. Sustained rate is set by the result buffer: a byte causes one to four
// characters (about 1.35 on average); the next byte waits in the input register. Reset
// (rst_n low, synchronous) clears both valid flags and the group, carry and line count
// state. Stalls on out_ch hold the buffer; in_ch.ready drops once a byte waits.
`timescale 1ns / 1ps
`default_nettype none
module base64_line_wrapped_encoder #(
  parameter int LINE_CHARS = 76
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  b64lw_in_if.sink    in_ch,
  b64lw_out_if.source out_ch
);
  import b64lw_pkg::*;

  logic       in_valid_r, in_valid_nxt;
  logic [7:0] byte_r;
  logic       fin_r;
  logic       accept;
  logic       load;
  logic       can_load;
  group_t     grp;

  assign load        = in_valid_r && can_load;
  assign in_ch.ready = !in_valid_r || load;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (accept) begin
      in_valid_nxt = 1'b1;
    end else if (load) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r <= in_ch.data_byte;
      fin_r  <= in_ch.final_byte;
    end
  end

  b64lw_group_enc #(
    .LINE_CHARS (LINE_CHARS)
  ) u_group_enc (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (load),
    .data_byte  (byte_r),
    .final_byte (fin_r),
    .grp        (grp)
  );

  b64lw_char_buf u_char_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (load),
    .grp      (grp),
    .can_load (can_load),
    .out_ch   (out_ch)
  );

  a_load_fills_buf: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> out_ch.valid)
    else $error("result buffer empty after load");

  a_msg_end_is_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.end_of_message |-> out_ch.end_of_run)
    else $error("message end without run end");

  a_waiting_byte_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !load |=> in_valid_r && $stable(byte_r) && $stable(fin_r))
    else $error("waiting byte lost");

  a_no_load_while_sending: assert property (@(posedge clk) disable iff (!rst_n)
    load && out_ch.valid |-> out_ch.ready && out_ch.end_of_run)
    else $error("buffer overwritten before last character taken");

endmodule
`default_nettype wire
